// ===== design/ctlmc_pkg.sv =====
`default_nettype none

package ctlmc_pkg;

  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned TAG_W         = 32;
  localparam int unsigned CNT_W         = 32;
  localparam int unsigned WAY_OUT_W     = 3;
  localparam int unsigned LFSR_W        = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  // The victim remainder is worked out four LFSR bits per step.
  localparam int unsigned MOD_STEP_BITS = 4;
  localparam int unsigned MOD_STEPS     = LFSR_W / MOD_STEP_BITS;

  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned CFG_DATA_W    = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OFFSET_BITS = 2'd0,
    REG_INDEX_BITS  = 2'd1,
    REG_WAYS_IN_USE = 2'd2
  } reg_index_t;

  localparam logic [4:0] OFFSET_BITS_RESET = 5'd2;
  localparam logic [3:0] INDEX_BITS_RESET  = 4'd6;
  localparam logic [3:0] WAYS_RESET        = 4'd1;

  typedef struct packed {
    logic [4:0] offset_bits;
    logic [3:0] index_bits;
    logic [3:0] ways_in_use;
  } cfg_t;

  typedef enum logic [1:0] {
    OUT_HIT        = 2'd0,
    OUT_COMPULSORY = 2'd1,
    OUT_CAPACITY   = 2'd2,
    OUT_CONFLICT   = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EVAL,
    BK_MOD,
    BK_REPL
  } back_state_t;

  function automatic logic [3:0] clamp_index_bits(input logic [3:0] ib,
                                                  input logic [3:0] max_ib);
    return (ib > max_ib) ? max_ib : ib;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

  // Taps x^16 + x^14 + x^13 + x^11, shifting right.
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] l);
    logic fb;
    fb = l[0] ^ l[2] ^ l[3] ^ l[5];
    return {fb, l[LFSR_W-1:1]};
  endfunction

endpackage

`default_nettype wire

// ===== design/ctlmc_front.sv =====
`default_nettype none

module ctlmc_front #(
  parameter int unsigned MAX_SETS = 256
) (
  input  wire logic                          start,
  input  wire logic [ctlmc_pkg::ADDR_W-1:0]  address,
  input  wire ctlmc_pkg::cfg_t               cfg,
  input  wire logic                          q_full,
  output logic                               busy,
  output logic                               push,
  output logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] set_idx,
  output logic [ctlmc_pkg::TAG_W-1:0]        tag
);

  localparam int unsigned SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam logic [3:0]  MAX_IB = 4'($clog2(MAX_SETS + 1) - 1);

  logic [3:0]                     ib;
  logic [ctlmc_pkg::ADDR_W-1:0]   shifted;
  logic [SET_W-1:0]               set_mask;

  assign busy = q_full;
  assign push = start && !q_full;

  // Dropping the offset first and then the index gives the tag without
  // ever shifting by more than the word width.
  always_comb begin
    ib       = ctlmc_pkg::clamp_index_bits(cfg.index_bits, MAX_IB);
    shifted  = address >> cfg.offset_bits;
    set_mask = ~({SET_W{1'b1}} << ib);
    set_idx  = shifted[SET_W-1:0] & set_mask;
    tag      = ctlmc_pkg::TAG_W'(shifted >> ib);
  end

endmodule

`default_nettype wire

// ===== design/ctlmc_queue.sv =====
`default_nettype none

module ctlmc_queue #(
  parameter int unsigned WIDTH = 40
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic                  full,
  output logic                  empty,
  output logic [WIDTH-1:0]      dout
);

  localparam int unsigned DEPTH   = ctlmc_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  assign full  = (count == COUNT_W'(DEPTH));
  assign empty = (count == '0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + COUNT_W'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== design/ctlmc_back.sv =====
`default_nettype none

module ctlmc_back #(
  parameter int unsigned MAX_SETS = 256,
  parameter int unsigned MAX_WAYS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ctlmc_pkg::cfg_t                   cfg,
  input  wire logic                              q_empty,
  input  wire logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] q_set,
  input  wire logic [ctlmc_pkg::TAG_W-1:0]       q_tag,
  output logic                                   pop,
  output logic                                   done,
  output logic [1:0]                             outcome,
  output logic [ctlmc_pkg::WAY_OUT_W-1:0]        way_used,
  output logic [ctlmc_pkg::CNT_W-1:0]            access_count,
  output logic [ctlmc_pkg::CNT_W-1:0]            hit_count,
  output logic [ctlmc_pkg::CNT_W-1:0]            compulsory_count,
  output logic [ctlmc_pkg::CNT_W-1:0]            capacity_count,
  output logic [ctlmc_pkg::CNT_W-1:0]            conflict_count
);

  localparam int unsigned SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam logic [3:0]  MAX_IB    = 4'($clog2(MAX_SETS + 1) - 1);
  localparam int unsigned MODCNT_W  =
    (ctlmc_pkg::MOD_STEPS > 1) ? $clog2(ctlmc_pkg::MOD_STEPS) : 1;
  localparam int unsigned TAG_W     = ctlmc_pkg::TAG_W;
  localparam int unsigned CNT_W     = ctlmc_pkg::CNT_W;
  localparam int unsigned LFSR_W    = ctlmc_pkg::LFSR_W;

  // One row per set: all tags and valid bits of the set, read and written whole.
  logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem [MAX_SETS];
  logic [MAX_WAYS-1:0]            vld_mem [MAX_SETS];
  logic [MAX_WAYS-1:0][TAG_W-1:0] rd_tags;
  logic [MAX_WAYS-1:0]            rd_valid;

  // A set whose row was never written reads as all ways invalid.
  logic [MAX_SETS-1:0]            row_live;

  ctlmc_pkg::back_state_t state;
  ctlmc_pkg::back_state_t state_next;

  logic [SET_W-1:0]        cur_set;
  logic [TAG_W-1:0]        cur_tag;
  logic [LFSR_W-1:0]       lfsr;
  logic [LFSR_W-1:0]       mod_val;
  logic [4:0]              rem;
  logic [4:0]              rem_next;
  logic [MODCNT_W-1:0]     mod_cnt;

  logic [CNT_W-1:0]        accesses_seen;
  logic [CNT_W-1:0]        hits_seen;
  logic [CNT_W-1:0]        compulsory_seen;
  logic [CNT_W-1:0]        capacity_seen;
  logic [CNT_W-1:0]        conflict_seen;
  ctlmc_pkg::outcome_t     outcome_q;
  logic [ctlmc_pkg::WAY_OUT_W-1:0] way_q;

  logic [4:0]              ways_eff;
  logic [3:0]              ib_eff;
  logic [MAX_WAYS-1:0]     eff_valid;
  logic                    hit_found;
  logic [WAY_W-1:0]        hit_way;
  logic                    fill_found;
  logic [WAY_W-1:0]        fill_way;
  logic [WAY_W-1:0]        victim_way;

  logic                    wr_en;
  logic                    emit;
  logic                    start_mod;
  logic [WAY_W-1:0]        wr_way;
  logic [WAY_W-1:0]        emit_way;
  ctlmc_pkg::outcome_t     emit_outcome;
  logic [MAX_WAYS-1:0][TAG_W-1:0] new_tags;
  logic [MAX_WAYS-1:0]     new_valid;

  // Geometry in effect.
  always_comb begin
    ways_eff = {1'b0, cfg.ways_in_use};
    if (ways_eff == 5'd0) begin
      ways_eff = 5'd1;
    end
    if (ways_eff > 5'(MAX_WAYS)) begin
      ways_eff = 5'(MAX_WAYS);
    end
    ib_eff = ctlmc_pkg::clamp_index_bits(cfg.index_bits, MAX_IB);
  end

  assign eff_valid  = row_live[cur_set] ? rd_valid : '0;
  assign victim_way = rem[WAY_W-1:0];

  // Lowest matching way and lowest free way among the ways in use.
  always_comb begin
    hit_found  = 1'b0;
    hit_way    = '0;
    fill_found = 1'b0;
    fill_way   = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (5'(i) < ways_eff) begin
        if (!hit_found && eff_valid[i] && (rd_tags[i] == cur_tag)) begin
          hit_found = 1'b1;
          hit_way   = WAY_W'(i);
        end
        if (!fill_found && !eff_valid[i]) begin
          fill_found = 1'b1;
          fill_way   = WAY_W'(i);
        end
      end
    end
  end

  // Restoring remainder of the stepped LFSR by the ways in use.
  always_comb begin
    logic [5:0] t;
    logic [4:0] r;
    r = rem;
    t = '0;
    for (int i = 0; i < ctlmc_pkg::MOD_STEP_BITS; i++) begin
      t = {r, mod_val[LFSR_W-1-i]};
      if (t >= {1'b0, ways_eff}) begin
        t = t - {1'b0, ways_eff};
      end
      r = t[4:0];
    end
    rem_next = r;
  end

  always_comb begin
    new_tags            = rd_tags;
    new_valid           = eff_valid;
    new_tags[wr_way]    = cur_tag;
    new_valid[wr_way]   = 1'b1;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ctlmc_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_next = ctlmc_pkg::BK_EVAL;
        end
      end
      ctlmc_pkg::BK_EVAL: begin
        if (!hit_found && !fill_found) begin
          state_next = ctlmc_pkg::BK_MOD;
        end else begin
          state_next = ctlmc_pkg::BK_IDLE;
        end
      end
      ctlmc_pkg::BK_MOD: begin
        if (mod_cnt == MODCNT_W'(ctlmc_pkg::MOD_STEPS - 1)) begin
          state_next = ctlmc_pkg::BK_REPL;
        end
      end
      ctlmc_pkg::BK_REPL: begin
        state_next = ctlmc_pkg::BK_IDLE;
      end
      default: begin
        state_next = ctlmc_pkg::BK_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    pop          = 1'b0;
    wr_en        = 1'b0;
    emit         = 1'b0;
    start_mod    = 1'b0;
    wr_way       = fill_way;
    emit_way     = hit_way;
    emit_outcome = ctlmc_pkg::OUT_HIT;
    case (state)
      ctlmc_pkg::BK_IDLE: begin
        pop = !q_empty;
      end
      ctlmc_pkg::BK_EVAL: begin
        if (hit_found) begin
          emit = 1'b1;
        end else if (fill_found) begin
          emit         = 1'b1;
          wr_en        = 1'b1;
          emit_way     = fill_way;
          emit_outcome = ctlmc_pkg::OUT_COMPULSORY;
        end else begin
          start_mod = 1'b1;
        end
      end
      ctlmc_pkg::BK_MOD: begin
      end
      ctlmc_pkg::BK_REPL: begin
        emit         = 1'b1;
        wr_en        = 1'b1;
        wr_way       = victim_way;
        emit_way     = victim_way;
        emit_outcome = (ib_eff == 4'd0) ? ctlmc_pkg::OUT_CAPACITY
                                        : ctlmc_pkg::OUT_CONFLICT;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ctlmc_pkg::BK_IDLE;
      row_live        <= '0;
      lfsr            <= ctlmc_pkg::LFSR_SEED;
      done            <= 1'b0;
      accesses_seen   <= '0;
      hits_seen       <= '0;
      compulsory_seen <= '0;
      capacity_seen   <= '0;
      conflict_seen   <= '0;
    end else begin
      state <= state_next;
      done  <= emit;
      if (wr_en) begin
        row_live[cur_set] <= 1'b1;
      end
      if (start_mod) begin
        lfsr <= ctlmc_pkg::lfsr_next(lfsr);
      end
      if (emit) begin
        accesses_seen <= ctlmc_pkg::sat_inc(accesses_seen);
        case (emit_outcome)
          ctlmc_pkg::OUT_HIT:        hits_seen       <= ctlmc_pkg::sat_inc(hits_seen);
          ctlmc_pkg::OUT_COMPULSORY: compulsory_seen <= ctlmc_pkg::sat_inc(compulsory_seen);
          ctlmc_pkg::OUT_CAPACITY:   capacity_seen   <= ctlmc_pkg::sat_inc(capacity_seen);
          ctlmc_pkg::OUT_CONFLICT:   conflict_seen   <= ctlmc_pkg::sat_inc(conflict_seen);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_set <= q_set;
      cur_tag <= q_tag;
    end
    if (start_mod) begin
      mod_val <= ctlmc_pkg::lfsr_next(lfsr);
      rem     <= '0;
      mod_cnt <= '0;
    end else if (state == ctlmc_pkg::BK_MOD) begin
      mod_val <= mod_val << ctlmc_pkg::MOD_STEP_BITS;
      rem     <= rem_next;
      mod_cnt <= mod_cnt + MODCNT_W'(1);
    end
    if (emit) begin
      outcome_q <= emit_outcome;
      way_q     <= ctlmc_pkg::WAY_OUT_W'(emit_way);
    end
  end

  // Tag memory: one row read at lookup, the same row written back on a miss.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[cur_set] <= new_tags;
      vld_mem[cur_set] <= new_valid;
    end
    if (pop) begin
      rd_tags  <= tag_mem[q_set];
      rd_valid <= vld_mem[q_set];
    end
  end

  assign outcome          = outcome_q;
  assign way_used         = way_q;
  assign access_count     = accesses_seen;
  assign hit_count        = hits_seen;
  assign compulsory_count = compulsory_seen;
  assign capacity_count   = capacity_seen;
  assign conflict_count   = conflict_seen;

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ctlmc_pkg::BK_EVAL || $past(state) == ctlmc_pkg::BK_REPL))
    else $error("result strobe without a finished lookup");

  a_repl_full_row: assert property (@(posedge clk) disable iff (rst)
    (state == ctlmc_pkg::BK_MOD) |-> row_live[cur_set])
    else $error("replacement started on a set that was never filled");

  a_victim_range: assert property (@(posedge clk) disable iff (rst)
    (state == ctlmc_pkg::BK_REPL) |-> (rem < ways_eff))
    else $error("victim way outside the ways in use");

  a_access_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (accesses_seen >= $past(accesses_seen)))
    else $error("access counter went backward");

endmodule

`default_nettype wire

// ===== design/cache_tag_lookup_miss_classifier_unit.sv =====
// A start transfer is written into the queue; the back end pops it and reads the set's
// tag row, then registers the result onto done after the lookup for a hit or a fill of a
// free way, or after the victim remainder unit has run when a way is replaced.
// The back end takes a new item from the queue only when it is done with the last one.
// A two-entry queue takes new items while earlier ones are looked up; the receiver cannot stall.
// Reset (synchronous, rst high): config 2/6/1, LFSR 0xACE1, counters zero, all sets empty.
`default_nettype none

module cache_tag_lookup_miss_classifier_unit #(
  parameter int unsigned MAX_SETS = 256,
  parameter int unsigned MAX_WAYS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [ctlmc_pkg::ADDR_W-1:0]        address,
  output logic                                     done,
  output logic [1:0]                               outcome,
  output logic [ctlmc_pkg::WAY_OUT_W-1:0]          way_used,
  output logic [ctlmc_pkg::CNT_W-1:0]              access_count,
  output logic [ctlmc_pkg::CNT_W-1:0]              hit_count,
  output logic [ctlmc_pkg::CNT_W-1:0]              compulsory_count,
  output logic [ctlmc_pkg::CNT_W-1:0]              capacity_count,
  output logic [ctlmc_pkg::CNT_W-1:0]              conflict_count,
  input  wire logic                                cfg_we,
  input  wire logic [ctlmc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [ctlmc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned ENT_W = SET_W + ctlmc_pkg::TAG_W;

  ctlmc_pkg::cfg_t              cfg;
  logic                         q_full;
  logic                         q_empty;
  logic                         push;
  logic                         pop;
  logic [SET_W-1:0]             set_idx;
  logic [ctlmc_pkg::TAG_W-1:0]  tag;
  logic [ENT_W-1:0]             q_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_bits <= ctlmc_pkg::OFFSET_BITS_RESET;
      cfg.index_bits  <= ctlmc_pkg::INDEX_BITS_RESET;
      cfg.ways_in_use <= ctlmc_pkg::WAYS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ctlmc_pkg::REG_OFFSET_BITS: cfg.offset_bits <= cfg_data[4:0];
        ctlmc_pkg::REG_INDEX_BITS:  cfg.index_bits  <= cfg_data[3:0];
        ctlmc_pkg::REG_WAYS_IN_USE: cfg.ways_in_use <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  ctlmc_front #(
    .MAX_SETS (MAX_SETS)
  ) u_front (
    .start   (start),
    .address (address),
    .cfg     (cfg),
    .q_full  (q_full),
    .busy    (busy),
    .push    (push),
    .set_idx (set_idx),
    .tag     (tag)
  );

  ctlmc_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   ({set_idx, tag}),
    .pop   (pop),
    .full  (q_full),
    .empty (q_empty),
    .dout  (q_dout)
  );

  ctlmc_back #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .q_empty          (q_empty),
    .q_set            (q_dout[ENT_W-1:ctlmc_pkg::TAG_W]),
    .q_tag            (q_dout[ctlmc_pkg::TAG_W-1:0]),
    .pop              (pop),
    .done             (done),
    .outcome          (outcome),
    .way_used         (way_used),
    .access_count     (access_count),
    .hit_count        (hit_count),
    .compulsory_count (compulsory_count),
    .capacity_count   (capacity_count),
    .conflict_count   (conflict_count)
  );

endmodule

`default_nettype wire
